// ===== hw/rtl/gqv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph quad vertex generator package
// Shared widths, codes and the saturation helper.
// ----------------------------------------------------------------------------
package gqv_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int TEX_W       = 64;
    localparam int MET_W       = 56;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    localparam logic [2:0] CFG_PAD_TOP       = 3'd0;
    localparam logic [2:0] CFG_PAD_LEFT      = 3'd1;
    localparam logic [2:0] CFG_PAD_BOTTOM    = 3'd2;
    localparam logic [2:0] CFG_PAD_RIGHT     = 3'd3;
    localparam logic [2:0] CFG_DESIRED_PAD   = 3'd4;
    localparam logic [2:0] CFG_ATLAS_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_ATLAS_HEIGHT  = 3'd6;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd7;

    localparam logic [2:0] CORNER_TL_A = 3'd0;
    localparam logic [2:0] CORNER_BL   = 3'd1;
    localparam logic [2:0] CORNER_BR_A = 3'd2;
    localparam logic [2:0] CORNER_TL_B = 3'd3;
    localparam logic [2:0] CORNER_BR_B = 3'd4;
    localparam logic [2:0] CORNER_TR   = 3'd5;

    localparam logic signed [29:0] POS_MAX = 30'sd8388607;
    localparam logic signed [29:0] POS_MIN = -30'sd8388608;

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        logic signed [23:0] r;
        if (v > POS_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < POS_MIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/glyph_quad_vertex_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph quad vertex generator
// Loads a glyph table and turns character requests into six textured vertices.
// ----------------------------------------------------------------------------
// Character: one table read, five passes through the shared multiplier and six
//   vertices; the vertices wait while the output stalls.
// Load: one shared restoring divider works out the four texture coordinates in turn.
// Begin, invalid characters and unknown kinds are handled without leaving idle.
// Reset returns control state, pen, scale, configuration registers and valid bits
//   to their defaults; the table memories are left undefined and are never swept.
module glyph_quad_vertex_generator #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gqv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gqv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, low to high: glyph_code 8, atlas_x 12, atlas_y 12, atlas_w 9,
    // atlas_h 9, raw_x_offset 10, raw_y_offset 10, raw_advance 11, start_x 14,
    // start_y 14, text_scale 16, zero fill 3
    input  logic [gqv_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: kind 2
    input  logic [gqv_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, low to high: vertex_x 24, vertex_y 24, tex_u 17, tex_v 17,
    // zero fill 6
    output logic [gqv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tuser: corner 3
    output logic [gqv_pkg::OUT_TUSER_W-1:0]    m_tuser,
    // m_tlast: last_vertex
    output logic                               m_tlast
);
    import gqv_pkg::*;

    // Only 256 codes can ever be addressed, so the table never needs more.
    localparam int DEPTH = (GLYPH_ENTRIES < 256) ? GLYPH_ENTRIES : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [16:0] ENTRIES = 17'(GLYPH_ENTRIES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_WR   = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_MX   = 4'd4;
    localparam logic [3:0] ST_MY   = 4'd5;
    localparam logic [3:0] ST_MW   = 4'd6;
    localparam logic [3:0] ST_MH   = 4'd7;
    localparam logic [3:0] ST_MA   = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    // Configuration registers.
    logic [7:0]  pad_top_reg, pad_left_reg, pad_bottom_reg, pad_right_reg, dpad_reg;
    logic [12:0] atlas_width_reg, atlas_height_reg, window_height_reg;

    logic [3:0]  state_reg, state_next;
    logic        s_accept;

    // Fields of the request being worked on.
    logic [7:0]  code_reg;
    logic [11:0] ax_reg, ay_reg;
    logic [8:0]  aw_reg, ah_reg;
    logic [9:0]  rxo_reg, ryo_reg;
    logic [10:0] radv_reg;

    logic signed [23:0] pen_x_reg, pen_y_reg;
    logic [15:0] scale_reg;
    logic [DEPTH-1:0] valid_reg;

    // Divider.
    logic [1:0]  div_idx_reg;
    logic [4:0]  div_cnt_reg;
    logic [12:0] rem_reg;
    logic [14:0] quo_reg;
    logic        force_reg;
    logic [15:0] tex_q_reg [0:3];

    // Corner positions of the quad being built.
    logic signed [29:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [2:0]  corner_reg;

    logic        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic [TEX_W-1:0] tex_rd;
    logic [MET_W-1:0] met_rd;

    // Request decode.
    logic [7:0]  in_code;
    logic        in_range;
    logic signed [13:0] in_sx, in_sy;
    logic signed [14:0] in_dy;

    assign in_code  = s_tdata[7:0];
    assign in_sx    = s_tdata[94:81];
    assign in_sy    = s_tdata[108:95];
    assign in_range = (17'(in_code) < ENTRIES);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Bottom-up start row; it may be negative when start_y lies below the window.
    assign in_dy = $signed({2'b00, window_height_reg}) - $signed({in_sy[13], in_sy});

    // Divider operands: padded left/top edge, then the rectangle size.
    logic signed [13:0] div_num;
    logic [12:0] den_w, den_h, div_den;
    logic [13:0] rem2;
    logic        rem_ge;

    assign den_w = (atlas_width_reg == 13'd0) ? 13'd1 : atlas_width_reg;
    assign den_h = (atlas_height_reg == 13'd0) ? 13'd1 : atlas_height_reg;

    always_comb
    begin
        unique case (div_idx_reg)
            2'd0:
            begin
                div_num = $signed({2'b00, ax_reg}) + $signed({6'd0, pad_left_reg})
                          - $signed({6'd0, dpad_reg});
                div_den = den_w;
            end
            2'd1:
            begin
                div_num = $signed({2'b00, ay_reg}) + $signed({6'd0, pad_top_reg})
                          - $signed({6'd0, dpad_reg});
                div_den = den_h;
            end
            2'd2:
            begin
                div_num = $signed({5'd0, aw_reg});
                div_den = den_w;
            end
            default:
            begin
                div_num = $signed({5'd0, ah_reg});
                div_den = den_h;
            end
        endcase
    end

    assign rem2   = {rem_reg, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, div_den});

    // Metrics of the entry being loaded, with the padding trimmed.
    logic [8:0] pad_w, pad_h;
    logic signed [10:0] m_w, m_h, m_xo, m_yo;
    logic signed [11:0] m_adv;

    assign pad_w = {1'b0, pad_left_reg} + {1'b0, pad_right_reg};
    assign pad_h = {1'b0, pad_top_reg} + {1'b0, pad_bottom_reg};
    assign m_w   = $signed({2'b00, aw_reg}) - $signed({2'b00, pad_w})
                   + $signed({2'b00, dpad_reg, 1'b0});
    assign m_h   = $signed({2'b00, ah_reg}) - $signed({2'b00, pad_h})
                   + $signed({2'b00, dpad_reg, 1'b0});
    assign m_xo  = $signed({rxo_reg[9], rxo_reg}) + $signed({3'd0, pad_left_reg})
                   - $signed({3'd0, dpad_reg});
    assign m_yo  = $signed({ryo_reg[9], ryo_reg}) + $signed({3'd0, pad_top_reg})
                   - $signed({3'd0, dpad_reg});
    assign m_adv = $signed({radv_reg[10], radv_reg}) - $signed({3'd0, pad_w});

    logic wr_en, rd_en;
    assign wr_en = (state_reg == ST_WR);
    assign rd_en = (state_reg == ST_RD);

    gqv_ram #(.WIDTH(TEX_W), .DEPTH(DEPTH)) u_tex_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (code_reg[AW-1:0]),
        .wdata ({tex_q_reg[3], tex_q_reg[2], tex_q_reg[1], tex_q_reg[0]}),
        .re    (rd_en),
        .raddr (code_reg[AW-1:0]),
        .rdata (tex_rd)
    );

    gqv_ram #(.WIDTH(MET_W), .DEPTH(DEPTH)) u_met_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (code_reg[AW-1:0]),
        .wdata ({m_adv, m_yo, m_xo, m_h, m_w}),
        .re    (rd_en),
        .raddr (code_reg[AW-1:0]),
        .rdata (met_rd)
    );

    // Fields of the entry read back for a character.
    logic [15:0] g_tx, g_ty, g_tw, g_th;
    logic signed [10:0] g_w, g_h, g_xo, g_yo;
    logic signed [11:0] g_adv;

    assign g_tx  = tex_rd[15:0];
    assign g_ty  = tex_rd[31:16];
    assign g_tw  = tex_rd[47:32];
    assign g_th  = tex_rd[63:48];
    assign g_w   = met_rd[10:0];
    assign g_h   = met_rd[21:11];
    assign g_xo  = met_rd[32:22];
    assign g_yo  = met_rd[43:33];
    assign g_adv = met_rd[55:44];

    // One multiplier, shared over the five metric passes.
    logic signed [11:0] mul_a;
    logic signed [28:0] prod;
    logic signed [29:0] prod_x, pen_x_x, pen_y_x;

    always_comb
    begin
        unique case (state_reg)
            ST_MY:   mul_a = {g_yo[10], g_yo};
            ST_MW:   mul_a = {g_w[10], g_w};
            ST_MH:   mul_a = {g_h[10], g_h};
            ST_MA:   mul_a = g_adv;
            default: mul_a = {g_xo[10], g_xo};
        endcase
    end

    assign prod    = mul_a * $signed({1'b0, scale_reg});
    assign prod_x  = {prod[28], prod};
    assign pen_x_x = {{6{pen_x_reg[23]}}, pen_x_reg};
    assign pen_y_x = {{6{pen_y_reg[23]}}, pen_y_reg};

    // Vertex selection for the current corner.
    logic        use_left, use_top;
    logic [16:0] u0, u1, v0, v1, vert_u, vert_v;
    logic signed [23:0] vert_x, vert_y;

    always_comb
    begin
        use_left = (corner_reg == CORNER_TL_A) || (corner_reg == CORNER_BL)
                   || (corner_reg == CORNER_TL_B);
        use_top  = (corner_reg == CORNER_TL_A) || (corner_reg == CORNER_TL_B)
                   || (corner_reg == CORNER_TR);
        u0 = {1'b0, g_tx};
        u1 = {1'b0, g_tx} + {1'b0, g_tw};
        v0 = {1'b0, g_ty};
        v1 = {1'b0, g_ty} + {1'b0, g_th};
        vert_x = sat24(use_left ? left_reg : right_reg);
        vert_y = sat24(use_top ? top_reg : bottom_reg);
        vert_u = use_left ? u0 : u1;
        vert_v = use_top ? v0 : v1;
    end

    logic out_load;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == KIND_LOAD && in_range)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (s_tuser == KIND_CHAR && in_range
                             && valid_reg[in_code[AW-1:0]])
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 5'd16 && div_idx_reg == 2'd3)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:   state_next = ST_IDLE;
            ST_RD:   state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MW;
            ST_MW:   state_next = ST_MH;
            ST_MH:   state_next = ST_MA;
            ST_MA:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_load && corner_reg == CORNER_TR)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pad_top_reg       <= 8'd0;
            pad_left_reg      <= 8'd0;
            pad_bottom_reg    <= 8'd0;
            pad_right_reg     <= 8'd0;
            dpad_reg          <= 8'd8;
            atlas_width_reg   <= 13'd512;
            atlas_height_reg  <= 13'd512;
            window_height_reg <= 13'd0;
            pen_x_reg         <= '0;
            pen_y_reg         <= '0;
            scale_reg         <= 16'd256;
            valid_reg         <= '0;
            div_idx_reg       <= 2'd0;
            div_cnt_reg       <= 5'd0;
            corner_reg        <= CORNER_TL_A;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_PAD_TOP:       pad_top_reg       <= cfg_wdata[7:0];
                    CFG_PAD_LEFT:      pad_left_reg      <= cfg_wdata[7:0];
                    CFG_PAD_BOTTOM:    pad_bottom_reg    <= cfg_wdata[7:0];
                    CFG_PAD_RIGHT:     pad_right_reg     <= cfg_wdata[7:0];
                    CFG_DESIRED_PAD:   dpad_reg          <= cfg_wdata[7:0];
                    CFG_ATLAS_WIDTH:   atlas_width_reg   <= cfg_wdata;
                    CFG_ATLAS_HEIGHT:  atlas_height_reg  <= cfg_wdata;
                    CFG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata;
                    default:           ;
                endcase
            end

            // A begin request places the pen and sets the scale; y is flipped to count bottom-up.
            if (s_accept && s_tuser == KIND_BEGIN)
            begin
                pen_x_reg <= {{2{in_sx[13]}}, in_sx, 8'd0};
                pen_y_reg <= {in_dy[14], in_dy, 8'd0};
                scale_reg <= s_tdata[124:109];
            end

            if (state_reg == ST_DIV)
            begin
                if (div_cnt_reg == 5'd16)
                begin
                    div_cnt_reg <= 5'd0;
                    div_idx_reg <= div_idx_reg + 2'd1;
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                end
            end

            if (state_reg == ST_WR)
            begin
                valid_reg[code_reg[AW-1:0]] <= 1'b1;
            end

            if (state_reg == ST_MA)
            begin
                pen_x_reg <= sat24(pen_x_x + prod_x);
            end

            if (out_load)
            begin
                corner_reg <= (corner_reg == CORNER_TR) ? CORNER_TL_A
                                                        : corner_reg + 3'd1;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            code_reg <= in_code;
            ax_reg   <= s_tdata[19:8];
            ay_reg   <= s_tdata[31:20];
            aw_reg   <= s_tdata[40:32];
            ah_reg   <= s_tdata[49:41];
            rxo_reg  <= s_tdata[59:50];
            ryo_reg  <= s_tdata[69:60];
            radv_reg <= s_tdata[80:70];
        end

        // Restoring division of num * 65536 by den. A quotient that would not
        // fit in 16 bits is forced to all ones; a non-positive numerator
        // simply runs with a zero remainder.
        if (state_reg == ST_DIV)
        begin
            if (div_cnt_reg == 5'd0)
            begin
                force_reg <= (div_num > 14'sd0)
                             && (div_num >= $signed({1'b0, div_den}));
                rem_reg   <= ((div_num > 14'sd0)
                              && (div_num < $signed({1'b0, div_den})))
                             ? div_num[12:0] : 13'd0;
                quo_reg   <= 15'd0;
            end
            else
            begin
                rem_reg <= rem_ge ? 13'(rem2 - {1'b0, div_den}) : rem2[12:0];
                quo_reg <= {quo_reg[13:0], rem_ge};
                if (div_cnt_reg == 5'd16)
                begin
                    tex_q_reg[div_idx_reg] <= force_reg ? 16'hFFFF : {quo_reg, rem_ge};
                end
            end
        end

        unique case (state_reg)
            ST_MX:   left_reg   <= pen_x_x + prod_x;
            ST_MY:   top_reg    <= pen_y_x - prod_x;
            ST_MW:   right_reg  <= left_reg + prod_x;
            ST_MH:   bottom_reg <= top_reg - prod_x;
            default: ;
        endcase

        if (out_load)
        begin
            m_tdata_reg <= {6'd0, vert_v, vert_u, vert_y, vert_x};
            m_tuser_reg <= corner_reg;
            m_tlast_reg <= (corner_reg == CORNER_TR);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hw/rtl/gqv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module gqv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/gqv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph quad vertex generator checker
// Port-level properties of the vertex stream, bound to the top level.
// ----------------------------------------------------------------------------
module gqv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gqv_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [gqv_pkg::OUT_TUSER_W-1:0] m_tuser,
    input logic                            m_tlast
);
    import gqv_pkg::*;

    // A stalled vertex holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled vertex changed");

    // The last flag marks exactly the top-right corner.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == CORNER_TR)))
        else $error("last flag and corner disagree");

    // Vertices of one glyph follow each other with no gap.
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
        else $error("corner sequence broken");

    // No new request is taken while a glyph is only partly delivered.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken during a glyph");

endmodule

bind glyph_quad_vertex_generator gqv_checker u_gqv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph quad vertex generator testbench
// Loads glyph entries under several padding and atlas settings, draws strings
// of characters and checks every vertex against a built-in predictor of the
// table, pen and scale arithmetic, with random bursts and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import gqv_pkg::*;

    // Kind code that the block ignores.
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         code;
        logic [11:0]        ax;
        logic [11:0]        ay;
        logic [8:0]         aw;
        logic [8:0]         ah;
        logic signed [9:0]  xo;
        logic signed [9:0]  yo;
        logic signed [10:0] adv;
        logic signed [13:0] sx;
        logic signed [13:0] sy;
        logic [15:0]        scale;
    } glyph_req_t;

    localparam int REQ_W = $bits(glyph_req_t);

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [2:0]         corner;
        logic               last;
    } vertex_t;

    typedef struct {
        longint tx, ty, tw, th, w, h, xo, yo, adv;
    } glyph_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic m_tlast;

    glyph_quad_vertex_generator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: a private copy of table, pen, scale and registers.
    glyph_entry_t glyph_table [256];
    bit           glyph_loaded [256];
    longint       pen_x, pen_y, pen_scale;
    longint       regs [8];

    glyph_req_t   pending_reqs[$];
    vertex_t      expected_vertices[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           long_hold = 1'b0;
    bit           stall_enable = 1'b1;

    function automatic longint clamp24(longint v);
        if (v > 8388607)
        begin
            return 8388607;
        end
        if (v < -8388608)
        begin
            return -8388608;
        end
        return v;
    endfunction

    function automatic longint texel_to_q16(longint num, longint div);
        longint q;
        if (num <= 0)
        begin
            return 0;
        end
        if (div == 0)
        begin
            div = 1;
        end
        q = (num * 65536) / div;
        return (q > 65535) ? 65535 : q;
    endfunction

    // Applies one accepted request to the table and pen, queuing any vertices.
    task automatic predict_vertices(input glyph_req_t r);
        longint pl, pt, dp, s, left, top, right, bottom;
        longint xs [6], ys [6], us [6], vs [6];
        glyph_entry_t g;
        vertex_t vx;
        pt = regs[CFG_PAD_TOP];
        pl = regs[CFG_PAD_LEFT];
        dp = regs[CFG_DESIRED_PAD];
        if (r.kind == KIND_LOAD)
        begin
            g.tx  = texel_to_q16(longint'(r.ax) + pl - dp, regs[CFG_ATLAS_WIDTH]);
            g.ty  = texel_to_q16(longint'(r.ay) + pt - dp, regs[CFG_ATLAS_HEIGHT]);
            g.tw  = texel_to_q16(longint'(r.aw), regs[CFG_ATLAS_WIDTH]);
            g.th  = texel_to_q16(longint'(r.ah), regs[CFG_ATLAS_HEIGHT]);
            g.w   = longint'(r.aw) - (pl + regs[CFG_PAD_RIGHT] - 2 * dp);
            g.h   = longint'(r.ah) - (pt + regs[CFG_PAD_BOTTOM] - 2 * dp);
            g.xo  = longint'(r.xo) + pl - dp;
            g.yo  = longint'(r.yo) + pt - dp;
            g.adv = longint'(r.adv) - (pl + regs[CFG_PAD_RIGHT]);
            glyph_table[r.code] = g;
            glyph_loaded[r.code] = 1'b1;
        end
        else if (r.kind == KIND_BEGIN)
        begin
            pen_x = clamp24(longint'(r.sx) * 256);
            pen_y = clamp24((regs[CFG_WINDOW_HEIGHT] - longint'(r.sy)) * 256);
            pen_scale = r.scale;
        end
        else if (r.kind == KIND_CHAR && glyph_loaded[r.code])
        begin
            g = glyph_table[r.code];
            s = pen_scale;
            left = pen_x + g.xo * s;
            top = pen_y - g.yo * s;
            right = left + g.w * s;
            bottom = top - g.h * s;
            pen_x = clamp24(pen_x + g.adv * s);
            xs = '{left, left, right, left, right, right};
            ys = '{top, bottom, bottom, top, bottom, top};
            us = '{g.tx, g.tx, g.tx + g.tw, g.tx, g.tx + g.tw, g.tx + g.tw};
            vs = '{g.ty, g.ty + g.th, g.ty + g.th, g.ty, g.ty + g.th, g.ty};
            for (int k = 0; k < 6; k++)
            begin
                vx.x = 24'(clamp24(xs[k]));
                vx.y = 24'(clamp24(ys[k]));
                vx.u = 17'(us[k]);
                vx.v = 17'(vs[k]);
                vx.corner = 3'(k);
                vx.last = (k == 5);
                expected_vertices.push_back(vx);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Driver: presents queued requests in bursts with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    glyph_req_t cur_req;
    bit in_taken = 1'b0;

    // The block may drop tready right after taking a request, so acceptance is
    // recorded at the rising edge where it happens.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_vertices(cur_req);
            end
            if (!s_tvalid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tuser <= cur_req.kind;
                    s_tdata <= {3'b000, cur_req.scale, cur_req.sy, cur_req.sx, cur_req.adv,
                                cur_req.yo, cur_req.xo, cur_req.ah, cur_req.aw, cur_req.ay,
                                cur_req.ax, cur_req.code};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left = burst_left - 1;
                    if (burst_left == 0 && $urandom_range(0, 2) != 0)
                    begin
                        gap_left = $urandom_range(1, 15);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with an optional long hold-off.
    int stall_phase = 0;
    always @(negedge clk)
    begin
        stall_phase = stall_phase + 1;
        if (long_hold)
        begin
            m_tready <= 1'b0;
        end
        else if (!stall_enable)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ((stall_phase % 11) < 7) && ($urandom_range(0, 5) != 0);
        end
    end

    // Monitor: compares each vertex with the oldest expected one.
    vertex_t got_v, want_v;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || long_hold)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got_v.x = m_tdata[23:0];
                got_v.y = m_tdata[47:24];
                got_v.u = m_tdata[64:48];
                got_v.v = m_tdata[81:65];
                got_v.corner = m_tuser;
                got_v.last = m_tlast;
                if (expected_vertices.size() == 0)
                begin
                    report_mismatch("unexpected vertex corner", got_v.corner, -1);
                end
                else
                begin
                    want_v = expected_vertices.pop_front();
                    if (got_v.x != want_v.x) report_mismatch("vertex_x", got_v.x, want_v.x);
                    if (got_v.y != want_v.y) report_mismatch("vertex_y", got_v.y, want_v.y);
                    if (got_v.u != want_v.u) report_mismatch("tex_u", got_v.u, want_v.u);
                    if (got_v.v != want_v.v) report_mismatch("tex_v", got_v.v, want_v.v);
                    if (got_v.corner != want_v.corner)
                        report_mismatch("corner", got_v.corner, want_v.corner);
                    if (got_v.last != want_v.last)
                        report_mismatch("last_vertex", got_v.last, want_v.last);
                end
            end
            // The guard allows for a load running the divider and for receiver stalls.
            if (idle_cycles > 4000)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic glyph_req_t make_req(input logic [1:0] kind, input logic [7:0] code);
        glyph_req_t r;
        r = glyph_req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        r.kind = kind;
        r.code = code;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input longint val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued request is taken and all vertices have come out.
    task automatic drain;
        while (pending_reqs.size() > 0 || s_tvalid || expected_vertices.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    // A string: one begin then characters, mostly from the code range that the loads use.
    task automatic queue_string(input int n_chars, input bit big_scale);
        glyph_req_t r;
        r = make_req(KIND_BEGIN, 8'd0);
        if (!big_scale)
        begin
            r.scale = 16'($urandom_range(0, 1024));
        end
        pending_reqs.push_back(r);
        for (int i = 0; i < n_chars; i++)
        begin
            r = make_req(KIND_CHAR, 8'($urandom_range(0, 31)));
            if ($urandom_range(0, 9) == 0)
            begin
                r.code = 8'($urandom);
            end
            pending_reqs.push_back(r);
        end
    endtask

    glyph_req_t dreq;

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            glyph_loaded[i] = 1'b0;
        end
        pen_x = 0;
        pen_y = 0;
        pen_scale = 256;
        regs = '{0, 0, 0, 0, 8, 512, 512, 0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: defaults, extremes of the load fields, unknown kind, invalid code.
        dreq = make_req(KIND_CHAR, 8'd200);
        pending_reqs.push_back(dreq);
        dreq = make_req(KIND_NONE, 8'd5);
        pending_reqs.push_back(dreq);
        dreq = '{KIND_LOAD, 8'd0, 12'd0, 12'd0, 9'd0, 9'd0, -10'sd512, -10'sd512,
                 -11'sd1024, 14'sd0, 14'sd0, 16'd0};
        pending_reqs.push_back(dreq);
        dreq = '{KIND_LOAD, 8'd255, 12'hFFF, 12'hFFF, 9'h1FF, 9'h1FF, 10'sd511, 10'sd511,
                 11'sd1023, 14'sd0, 14'sd0, 16'd0};
        pending_reqs.push_back(dreq);
        dreq = '{KIND_CHAR, 8'd0, 12'd0, 12'd0, 9'd0, 9'd0, 10'sd0, 10'sd0,
                 11'sd0, 14'sd0, 14'sd0, 16'd0};
        pending_reqs.push_back(dreq);
        dreq = '{KIND_BEGIN, 8'd0, 12'd0, 12'd0, 9'd0, 9'd0, 10'sd0, 10'sd0,
                 11'sd0, -14'sd8192, 14'sd8191, 16'hFFFF};
        pending_reqs.push_back(dreq);
        for (int i = 0; i < 3; i++)
        begin
            pending_reqs.push_back(make_req(KIND_CHAR, 8'd255));
            pending_reqs.push_back(make_req(KIND_CHAR, 8'd0));
        end
        dreq.sx = 14'sd8191;
        dreq.sy = -14'sd8192;
        dreq.scale = 16'd256;
        pending_reqs.push_back(dreq);
        pending_reqs.push_back(make_req(KIND_CHAR, 8'd255));
        pending_reqs.push_back(make_req(KIND_CHAR, 8'd0));
        drain();

        // Phases under several register settings: reload glyphs, then strings.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_PAD_TOP, 0);     write_reg(CFG_PAD_LEFT, 0);
                    write_reg(CFG_PAD_BOTTOM, 0);  write_reg(CFG_PAD_RIGHT, 0);
                    write_reg(CFG_DESIRED_PAD, 0); write_reg(CFG_ATLAS_WIDTH, 0);
                    write_reg(CFG_ATLAS_HEIGHT, 1); write_reg(CFG_WINDOW_HEIGHT, 0);
                end
                1:
                begin
                    write_reg(CFG_PAD_TOP, 255);    write_reg(CFG_PAD_LEFT, 255);
                    write_reg(CFG_PAD_BOTTOM, 255); write_reg(CFG_PAD_RIGHT, 255);
                    write_reg(CFG_DESIRED_PAD, 255); write_reg(CFG_ATLAS_WIDTH, 8191);
                    write_reg(CFG_ATLAS_HEIGHT, 4096); write_reg(CFG_WINDOW_HEIGHT, 8191);
                end
                default:
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        write_reg(3'(k), $urandom_range(0, 255));
                    end
                    write_reg(CFG_ATLAS_WIDTH, $urandom_range(1, 4096));
                    write_reg(CFG_ATLAS_HEIGHT, $urandom_range(1, 4096));
                    write_reg(CFG_WINDOW_HEIGHT, $urandom_range(0, 8191));
                end
            endcase
            stall_enable = (phase != 2);
            for (int i = 0; i < 12; i++)
            begin
                pending_reqs.push_back(make_req(KIND_LOAD, 8'($urandom_range(0, 31))));
            end
            while (pending_reqs.size() < 60)
            begin
                queue_string($urandom_range(1, 8), $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 15) == 0)
                begin
                    pending_reqs.push_back(make_req(KIND_NONE, 8'($urandom)));
                end
            end
            if (phase == 3)
            begin
                // Hold the output off long enough for the block to back up.
                long_hold = 1'b1;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            drain();
        end

        if (mismatch_count == 0 && expected_vertices.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
